### sv/sdtr_pkg.sv
// Shared types, codes and constants of the session date-time reporter.
// Used by sdtr_front, sdtr_back and session_date_time_reporter; no dependencies.
`timescale 1ns / 1ps

package sdtr_pkg;

  localparam int SLOTS       = 8;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_ENQ   = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] CL_OPEN   = 3'd0;
  localparam logic [2:0] CL_CLOSE  = 3'd1;
  localparam logic [2:0] CL_ENQ    = 3'd2;
  localparam logic [2:0] CL_TICK   = 3'd3;
  localparam logic [2:0] CL_REJECT = 3'd4;

  typedef struct packed {
    logic [2:0]  cls;
    logic [15:0] session;
    logic [7:0]  interval;
    logic [15:0] mjd;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
  } entry_t;

  function automatic logic [6:0] to_bcd(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] u;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    u = v - (6'(t) * 6'd10);
    return {t, u[3:0]};
  endfunction

endpackage

### sv/sdtr_front.sv
// Front end: takes requests, classifies them, converts time to BCD and queues them;
// ticks without valid time are dropped. Depends on sdtr_pkg.
`timescale 1ns / 1ps

module sdtr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          op,
  input  logic [15:0]         session,
  input  logic [7:0]          interval,
  input  logic                has_interval,
  input  logic                time_valid,
  input  logic [15:0]         mjd,
  input  logic [4:0]          hour,
  input  logic [5:0]          minute,
  input  logic [5:0]          second,
  input  logic                pop,
  output logic                busy,
  output logic                q_valid,
  output sdtr_pkg::entry_t    q_entry
);

  sdtr_pkg::entry_t              entries [sdtr_pkg::QDEPTH];
  sdtr_pkg::entry_t              req;
  logic [sdtr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sdtr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sdtr_pkg::QCNT_W-1:0]   count;
  logic                          accept;
  logic                          push;
  logic                          do_pop;

  assign busy    = (count == sdtr_pkg::QCNT_W'(sdtr_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_entry = entries[rd_ptr];
  assign accept  = start && !busy;
  // drop ticks without valid time here: they cause nothing
  assign push    = accept && !(op == sdtr_pkg::OP_TICK && !time_valid);
  assign do_pop  = pop && q_valid;

  always_comb begin
    req.session    = session;
    req.interval   = has_interval ? interval : 8'd0;
    req.mjd        = time_valid ? mjd : 16'd0;
    req.hour_bcd   = time_valid ? 6'(sdtr_pkg::to_bcd({1'b0, hour})) : 6'd0;
    req.minute_bcd = time_valid ? sdtr_pkg::to_bcd(minute) : 7'd0;
    req.second_bcd = time_valid ? sdtr_pkg::to_bcd(second) : 7'd0;
    unique case (op)
      sdtr_pkg::OP_OPEN:  req.cls = (session == 16'd0) ? sdtr_pkg::CL_REJECT
                                                       : sdtr_pkg::CL_OPEN;
      sdtr_pkg::OP_CLOSE: req.cls = (session == 16'd0) ? sdtr_pkg::CL_REJECT
                                                       : sdtr_pkg::CL_CLOSE;
      sdtr_pkg::OP_ENQ:   req.cls = (session == 16'd0) ? sdtr_pkg::CL_REJECT
                                                       : sdtr_pkg::CL_ENQ;
      default:            req.cls = sdtr_pkg::CL_TICK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= req;
        wr_ptr <= (wr_ptr == sdtr_pkg::QPTR_W'(sdtr_pkg::QDEPTH - 1)) ? '0
                  : wr_ptr + sdtr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sdtr_pkg::QPTR_W'(sdtr_pkg::QDEPTH - 1)) ? '0
                  : rd_ptr + sdtr_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) count <= count + sdtr_pkg::QCNT_W'(1);
      else if (!push && do_pop) count <= count - sdtr_pkg::QCNT_W'(1);
    end
  end

endmodule

### sv/sdtr_back.sv
// Back end: holds the session slot table and walks it one slot per cycle
// to carry out queued requests and emit results. Depends on sdtr_pkg.
`timescale 1ns / 1ps

module sdtr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  sdtr_pkg::entry_t    q_entry,
  output logic                pop,
  output logic                strobe,
  output logic                kind,
  output logic [15:0]         reply_session,
  output logic [15:0]         reply_mjd,
  output logic [5:0]          hour_bcd,
  output logic [6:0]          minute_bcd,
  output logic [6:0]          second_bcd,
  output logic [1:0]          status,
  output logic                last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                  state;
  logic [sdtr_pkg::SLOT_W-1:0] idx;
  sdtr_pkg::entry_t            cur;
  logic                        held_valid;
  logic [15:0]                 held_session;
  logic [sdtr_pkg::CNT_W-1:0]  cnt;
  logic [15:0]                 slot_session  [sdtr_pkg::SLOTS];
  logic [7:0]                  slot_interval [sdtr_pkg::SLOTS];
  logic [7:0]                  slot_elapsed  [sdtr_pkg::SLOTS];

  logic        at_end, hit_free, hit_match, armed, due;
  logic [7:0]  el_inc;
  logic        e_en, e_kind, e_last, done, wr_en, hold_en;
  logic [15:0] e_sess;
  logic [1:0]  e_status;
  logic [15:0] wr_sess;
  logic [7:0]  wr_ivl, wr_el;

  assign pop       = (state == S_IDLE) && q_valid;
  assign at_end    = (idx == sdtr_pkg::SLOT_W'(sdtr_pkg::SLOTS - 1));
  assign hit_free  = (slot_session[idx] == 16'd0);
  assign hit_match = (slot_session[idx] == cur.session);
  assign armed     = !hit_free && (slot_interval[idx] != 8'd0);
  assign el_inc    = slot_elapsed[idx] + 8'd1;
  assign due       = armed && (el_inc >= slot_interval[idx]);

  always_comb begin
    e_en     = 1'b0;
    e_kind   = sdtr_pkg::KIND_STATUS;
    e_sess   = cur.session;
    e_status = sdtr_pkg::ST_OK;
    e_last   = 1'b1;
    done     = 1'b0;
    wr_en    = 1'b0;
    wr_sess  = slot_session[idx];
    wr_ivl   = slot_interval[idx];
    wr_el    = slot_elapsed[idx];
    hold_en  = 1'b0;
    unique case (state)
      S_WALK: begin
        unique case (cur.cls)
          sdtr_pkg::CL_OPEN: begin
            if (hit_free) begin
              wr_en   = 1'b1;
              wr_sess = cur.session;
              wr_ivl  = 8'd0;
              wr_el   = 8'd0;
              e_en    = 1'b1;
              done    = 1'b1;
            end else if (at_end) begin
              e_en     = 1'b1;
              e_status = sdtr_pkg::ST_FULL;
              done     = 1'b1;
            end
          end
          sdtr_pkg::CL_CLOSE: begin
            if (hit_match) begin
              wr_en   = 1'b1;
              wr_sess = 16'd0;
              wr_ivl  = 8'd0;
              wr_el   = 8'd0;
              e_en    = 1'b1;
              done    = 1'b1;
            end else if (at_end) begin
              e_en     = 1'b1;
              e_status = sdtr_pkg::ST_UNKNOWN;
              done     = 1'b1;
            end
          end
          sdtr_pkg::CL_ENQ: begin
            if (hit_match) begin
              wr_en  = 1'b1;
              wr_ivl = cur.interval;
              wr_el  = 8'd0;
              e_en   = 1'b1;
              e_kind = sdtr_pkg::KIND_REPLY;
              done   = 1'b1;
            end else if (at_end) begin
              e_en     = 1'b1;
              e_status = sdtr_pkg::ST_UNKNOWN;
              done     = 1'b1;
            end
          end
          sdtr_pkg::CL_TICK: begin
            if (armed) begin
              wr_en = 1'b1;
              wr_el = due ? (el_inc - slot_interval[idx]) : el_inc;
            end
            // hold each due reply until the next one shows whether it is last
            if (due && cnt < sdtr_pkg::CNT_W'(sdtr_pkg::MAX_RESULTS)) begin
              hold_en = 1'b1;
              if (held_valid) begin
                e_en   = 1'b1;
                e_kind = sdtr_pkg::KIND_REPLY;
                e_sess = held_session;
                e_last = 1'b0;
              end
            end
            done = at_end;
          end
          default: begin
            e_en     = 1'b1;
            e_status = sdtr_pkg::ST_UNKNOWN;
            done     = 1'b1;
          end
        endcase
      end
      S_FLUSH: begin
        if (held_valid) begin
          e_en   = 1'b1;
          e_kind = sdtr_pkg::KIND_REPLY;
          e_sess = held_session;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      held_valid <= 1'b0;
      cnt        <= '0;
      strobe     <= 1'b0;
      for (int i = 0; i < sdtr_pkg::SLOTS; i++) begin
        slot_session[i]  <= 16'd0;
        slot_interval[i] <= 8'd0;
        slot_elapsed[i]  <= 8'd0;
      end
    end else begin
      strobe <= e_en;
      if (e_en) begin
        kind          <= e_kind;
        reply_session <= e_sess;
        status        <= (e_kind == sdtr_pkg::KIND_STATUS) ? e_status : sdtr_pkg::ST_OK;
        last          <= e_last;
        reply_mjd     <= (e_kind == sdtr_pkg::KIND_REPLY) ? cur.mjd : 16'd0;
        hour_bcd      <= (e_kind == sdtr_pkg::KIND_REPLY) ? cur.hour_bcd : 6'd0;
        minute_bcd    <= (e_kind == sdtr_pkg::KIND_REPLY) ? cur.minute_bcd : 7'd0;
        second_bcd    <= (e_kind == sdtr_pkg::KIND_REPLY) ? cur.second_bcd : 7'd0;
      end
      if (wr_en) begin
        slot_session[idx]  <= wr_sess;
        slot_interval[idx] <= wr_ivl;
        slot_elapsed[idx]  <= wr_el;
      end
      if (hold_en) begin
        held_valid   <= 1'b1;
        held_session <= slot_session[idx];
        cnt          <= cnt + sdtr_pkg::CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_entry;
            idx        <= '0;
            held_valid <= 1'b0;
            cnt        <= '0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          if (done) begin
            state <= (cur.cls == sdtr_pkg::CL_TICK) ? S_FLUSH : S_IDLE;
          end else begin
            idx <= idx + sdtr_pkg::SLOT_W'(1);
          end
        end
        S_FLUSH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/session_date_time_reporter.sv
// Top level of the session date-time reporter: front end with request queue
// and back end with the slot table. Depends on sdtr_pkg, sdtr_front, sdtr_back.
//
// Usage: drive op, session, interval, has_interval, time_valid, mjd, hour,
// minute and second with start high; the request is taken at a clock edge
// where busy is low. Open, close and enquiry give exactly one result; a
// one-second tick with valid time gives one reply per slot that comes due
// (none if nothing is due); a tick with invalid time is taken and dropped.
// Each result shows on the result ports for one cycle with strobe high;
// last marks the final result of a request. The receiver cannot stall.
// Requests pass through a two-entry queue; busy is high while it is full.
// The back end walks the slot table one slot per cycle. Open, close and
// enquiry stop at the slot they hit or at the last slot; a rejected request
// stops at the first slot; a tick walks every slot and then passes through a
// flush state that emits its last held reply, if any. The back end takes the
// next request from the queue only once it is back in idle after the last.
// Reset (rst, synchronous) empties the queue and frees all slots.
`timescale 1ns / 1ps

module session_date_time_reporter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [15:0] session,
  input  logic [7:0]  interval,
  input  logic        has_interval,
  input  logic        time_valid,
  input  logic [15:0] mjd,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  output logic        strobe,
  output logic        kind,
  output logic [15:0] reply_session,
  output logic [15:0] reply_mjd,
  output logic [5:0]  hour_bcd,
  output logic [6:0]  minute_bcd,
  output logic [6:0]  second_bcd,
  output logic [1:0]  status,
  output logic        last
);

  logic             q_valid;
  logic             pop;
  sdtr_pkg::entry_t q_entry;

  sdtr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .session      (session),
    .interval     (interval),
    .has_interval (has_interval),
    .time_valid   (time_valid),
    .mjd          (mjd),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .pop          (pop),
    .busy         (busy),
    .q_valid      (q_valid),
    .q_entry      (q_entry)
  );

  sdtr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .pop           (pop),
    .strobe        (strobe),
    .kind          (kind),
    .reply_session (reply_session),
    .reply_mjd     (reply_mjd),
    .hour_bcd      (hour_bcd),
    .minute_bcd    (minute_bcd),
    .second_bcd    (second_bcd),
    .status        (status),
    .last          (last)
  );

endmodule
